// ===== sv/olpe_pkg.sv =====
// Shared constants, codes and transaction types for the ordered list position engine.
package olpe_pkg;

  localparam int CAPACITY = 16;
  localparam int KEY_W    = 32;
  localparam int POS_W    = 5;
  localparam int FOUND_W  = 4;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int IDX_W    = $clog2(CAPACITY);

  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_DELETE = 2'd1,
    ACT_MODIFY = 2'd2,
    ACT_SEARCH = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_RANGE    = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_e;

  typedef struct packed {
    action_e                   action;
    logic [POS_W-1:0]          pos;
    logic signed [KEY_W-1:0]   key;
  } item_t;

  typedef struct packed {
    status_e                   status;
    logic signed [KEY_W-1:0]   old_key;
    logic [FOUND_W-1:0]        found_pos;
    logic [CNT_W-1:0]          length;
  } result_t;

  // Per-cell update select
  typedef struct packed {
    logic load;
    logic take_lo;
    logic take_hi;
  } cell_ctrl_t;

endpackage

// ===== sv/olpe_cell.sv =====
// One list slot: holds a key, shifts from either neighbor, compares against the search key.
module olpe_cell (
  input  logic                         clk_i,
  input  olpe_pkg::cell_ctrl_t         ctrl_i,
  input  logic [olpe_pkg::KEY_W-1:0]   key_i,
  input  logic [olpe_pkg::KEY_W-1:0]   lo_i,
  input  logic [olpe_pkg::KEY_W-1:0]   hi_i,
  output logic [olpe_pkg::KEY_W-1:0]   data_o,
  output logic                         match_o
);
  import olpe_pkg::*;

  logic [KEY_W-1:0] data_q, data_d;

  always_comb begin
    data_d = data_q;
    if (ctrl_i.load) begin
      data_d = key_i;
    end else if (ctrl_i.take_lo) begin
      data_d = lo_i;
    end else if (ctrl_i.take_hi) begin
      data_d = hi_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o  = data_q;
  assign match_o = (data_q == key_i);

endmodule

// ===== sv/ordered_list_position_engine.sv =====
// A result strobes on done_o after the s1 stage and the result register hold it.
// Throughput: one transaction per cycle; busy_o stays low, all cells shift together.
// Search compares every cell at once, then a priority encode over the registered hits.
// Reset clears the length and the pipeline; cell contents stay unknown until written.
// The receiver cannot stall; each result is valid for exactly one cycle.
module ordered_list_position_engine (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  olpe_pkg::item_t   item_i,
  output logic              busy_o,
  output logic              done_o,
  output olpe_pkg::result_t result_o
);
  import olpe_pkg::*;

  logic                        accept;
  logic [CNT_W-1:0]            count_q, count_d;
  cell_ctrl_t [CAPACITY-1:0]   ctrl;
  logic [CAPACITY-1:0][KEY_W-1:0] cell_data;
  logic [CAPACITY-1:0]         cell_match;
  logic [CAPACITY-1:0][KEY_W-1:0] lo_data, hi_data;

  status_e                     status_c;
  logic [KEY_W-1:0]            old_c;

  logic                        s1_valid_q, s1_search_q;
  status_e                     s1_status_q;
  logic [KEY_W-1:0]            s1_old_q;
  logic [CNT_W-1:0]            s1_len_q;
  logic [CAPACITY-1:0]         s1_match_q, s1_match_d;

  logic                        done_q;
  result_t                     result_q, result_d;

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  // Decode the transaction into per-cell controls
  always_comb begin
    status_c = ST_OK;
    old_c    = '0;
    count_d  = count_q;
    ctrl     = '0;
    unique case (item_i.action)
      ACT_INSERT: begin
        if (item_i.pos > count_q) begin
          status_c = ST_RANGE;
        end else if (count_q >= CNT_W'(CAPACITY)) begin
          status_c = ST_FULL;
        end else if (accept) begin
          count_d = count_q + 1'b1;
          for (int i = 0; i < CAPACITY; i++) begin
            ctrl[i].load    = (item_i.pos == POS_W'(i));
            ctrl[i].take_lo = (POS_W'(i) > item_i.pos) && (CNT_W'(i) <= count_q);
          end
        end
      end
      ACT_DELETE: begin
        if (item_i.pos >= count_q) begin
          status_c = ST_RANGE;
        end else if (accept) begin
          count_d = count_q - 1'b1;
          for (int i = 0; i < CAPACITY; i++) begin
            ctrl[i].take_hi = (POS_W'(i) >= item_i.pos) && (CNT_W'(i + 1) < count_q);
          end
        end
      end
      ACT_MODIFY: begin
        if (item_i.pos >= count_q) begin
          status_c = ST_RANGE;
        end else begin
          old_c = cell_data[item_i.pos[IDX_W-1:0]];
          for (int i = 0; i < CAPACITY; i++) begin
            ctrl[i].load = accept && (item_i.pos == POS_W'(i));
          end
        end
      end
      ACT_SEARCH: begin
        status_c = ST_NOTFOUND;
      end
      default: status_c = ST_OK;
    endcase
  end

  // Only hits inside the current length count
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      s1_match_d[i] = cell_match[i] && (CNT_W'(i) < count_q);
    end
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    if (g == 0) begin : g_first
      assign lo_data[g] = '0;
    end else begin : g_mid
      assign lo_data[g] = cell_data[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign hi_data[g] = '0;
    end else begin : g_up
      assign hi_data[g] = cell_data[g+1];
    end
    olpe_cell u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl[g]),
      .key_i   (item_i.key),
      .lo_i    (lo_data[g]),
      .hi_i    (hi_data[g]),
      .data_o  (cell_data[g]),
      .match_o (cell_match[g])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      s1_valid_q <= 1'b0;
      done_q     <= 1'b0;
    end else begin
      if (accept) begin
        count_q <= count_d;
      end
      s1_valid_q <= accept;
      done_q     <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_search_q <= (item_i.action == ACT_SEARCH);
      s1_status_q <= status_c;
      s1_old_q    <= old_c;
      s1_len_q    <= count_d;
      s1_match_q  <= s1_match_d;
    end
  end

  // Pick the lowest matching position
  always_comb begin
    result_d.status    = s1_status_q;
    result_d.old_key   = s1_old_q;
    result_d.found_pos = '0;
    result_d.length    = s1_len_q;
    if (s1_search_q) begin
      for (int i = CAPACITY - 1; i >= 0; i--) begin
        if (s1_match_q[i]) begin
          result_d.status    = ST_OK;
          result_d.found_pos = FOUND_W'(i);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q) begin
      result_q <= result_d;
    end
  end

  assign done_o   = done_q;
  assign result_o = result_q;

endmodule

// ===== sv/olpe_checker.sv =====
// Port-level checks for the ordered list position engine, bound to the top level.
module olpe_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start_i,
  input olpe_pkg::item_t   item_i,
  input logic              busy_o,
  input logic              done_o,
  input olpe_pkg::result_t result_o
);
  import olpe_pkg::*;

  logic accept;
  assign accept = start_i && !busy_o;

  a_done_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##2 done_o)
    else $error("accepted transaction produced no result");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(accept, 2))
    else $error("result without a transaction");

  a_full_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && result_o.status == ST_FULL) |-> (result_o.length == CNT_W'(CAPACITY)))
    else $error("full status with short list");

  a_search_old: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && item_i.action == ACT_SEARCH) |-> ##2 (result_o.old_key == '0))
    else $error("search returned an old key");

endmodule

bind ordered_list_position_engine olpe_checker u_olpe_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .start_i  (start_i),
  .item_i   (item_i),
  .busy_o   (busy_o),
  .done_o   (done_o),
  .result_o (result_o)
);

// ===== verif/testbench.sv =====
// Self-checking testbench for the ordered list position engine: predictor plus mixed traffic.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import olpe_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 6;

  logic    clk_i = 1'b0;
  logic    rst_ni;
  logic    start_i;
  item_t   item_i;
  logic    busy_o;
  logic    done_o;
  result_t result_o;

  ordered_list_position_engine dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .item_i   (item_i),
    .busy_o   (busy_o),
    .done_o   (done_o),
    .result_o (result_o)
  );

  always #2 clk_i = ~clk_i;

  logic signed [KEY_W-1:0] list_keys[$];
  result_t                 pending_results[$];
  int                      mismatch_count = 0;
  int                      idle_cycles    = 0;
  int                      sender_idle_pct = 0;
  bit                      filling = 1'b1;

  // Apply one action to the list copy and return the result it produces.
  function automatic result_t apply_list_op(input item_t it);
    result_t r;
    int      len;
    int      p;
    bit      hit;
    r   = '0;
    len = list_keys.size();
    p   = int'(it.pos);
    hit = 1'b0;
    r.status = ST_OK;
    case (it.action)
      ACT_INSERT: begin
        if (p > len) r.status = ST_RANGE;
        else if (len >= CAPACITY) r.status = ST_FULL;
        else list_keys.insert(p, it.key);
      end
      ACT_DELETE: begin
        if (p >= len) r.status = ST_RANGE;
        else list_keys.delete(p);
      end
      ACT_MODIFY: begin
        if (p >= len) begin
          r.status = ST_RANGE;
        end else begin
          r.old_key    = list_keys[p];
          list_keys[p] = it.key;
        end
      end
      default: begin
        r.status = ST_NOTFOUND;
        for (int i = 0; i < len; i++) begin
          if (!hit && list_keys[i] == it.key) begin
            hit         = 1'b1;
            r.status    = ST_OK;
            r.found_pos = FOUND_W'(i);
          end
        end
      end
    endcase
    r.length = CNT_W'(list_keys.size());
    return r;
  endfunction

  function automatic item_t make_item(input action_e act, input int p,
                                      input logic signed [KEY_W-1:0] k);
    item_t it;
    it.action = act;
    it.pos    = POS_W'(p);
    it.key    = k;
    return it;
  endfunction

  task automatic note_failure(input string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("%0t: %s", $time, msg);
  endtask

  // Drive one transaction, with random sender gaps, and record its expected result.
  task automatic send_item(input item_t it);
    while ($urandom_range(1, 100) <= sender_idle_pct) begin
      @(negedge clk_i);
      start_i <= 1'b0;
      item_i  <= item_t'({($bits(item_t) - KEY_W)'($urandom), $urandom});
    end
    @(negedge clk_i);
    start_i <= 1'b1;
    item_i  <= it;
    do @(posedge clk_i); while (busy_o);
    pending_results.push_back(apply_list_op(it));
  endtask

  task automatic stop_sending();
    @(negedge clk_i);
    start_i <= 1'b0;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (pending_results.size() == 0) begin
        note_failure($sformatf("unexpected result %p", result_o));
      end else begin
        result_t exp_r;
        exp_r = pending_results.pop_front();
        if (result_o.status !== exp_r.status || result_o.old_key !== exp_r.old_key ||
            result_o.found_pos !== exp_r.found_pos || result_o.length !== exp_r.length)
          note_failure($sformatf({"mismatch: exp status=%0d old=%h found=%0d len=%0d, ",
                                  "got status=%0d old=%h found=%0d len=%0d"},
            exp_r.status, exp_r.old_key, exp_r.found_pos, exp_r.length,
            result_o.status, result_o.old_key, result_o.found_pos, result_o.length));
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start_i && !busy_o) || done_o) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog expired, %0d results outstanding", pending_results.size());
        $display("** ordered_list_position_engine: FAILED **");
        $finish;
      end
    end
  end

  // Empty list errors, extreme keys, filling to capacity, duplicates and the far end.
  task automatic test_directed();
    sender_idle_pct = 0;
    send_item(make_item(ACT_SEARCH, 0, 32'sd5));
    send_item(make_item(ACT_DELETE, 0, 32'sd0));
    send_item(make_item(ACT_MODIFY, 0, 32'sd7));
    send_item(make_item(ACT_INSERT, 1, 32'sd9));
    send_item(make_item(ACT_INSERT, 0, 32'sh7FFF_FFFF));
    send_item(make_item(ACT_INSERT, 0, 32'sh8000_0000));
    send_item(make_item(ACT_INSERT, 2, -32'sd1));
    send_item(make_item(ACT_INSERT, 1, 32'sd0));
    // fill to capacity, mixing inserts at position 1 and at the back with duplicate keys
    for (int i = 0; i < 12; i++)
      send_item(make_item(ACT_INSERT, (i % 2) ? list_keys.size() : 1,
                          (i < 11) ? KEY_W'(i % 4) : 32'sh1357_9BDF));
    send_item(make_item(ACT_INSERT, CAPACITY, 32'sd4));
    send_item(make_item(ACT_INSERT, 31, 32'sd4));
    send_item(make_item(ACT_SEARCH, 31, 32'sd2));
    send_item(make_item(ACT_SEARCH, 0, 32'sh1357_9BDF));
    send_item(make_item(ACT_MODIFY, CAPACITY - 1, 32'shDEAD_BEEF));
    send_item(make_item(ACT_DELETE, CAPACITY, 32'sd0));
    send_item(make_item(ACT_DELETE, 0, 32'sd0));
    stop_sending();
  endtask

  function automatic logic signed [KEY_W-1:0] pick_key(input bit prefer_present);
    int sel;
    sel = $urandom_range(0, 9);
    if (prefer_present && list_keys.size() != 0 && sel < 7)
      return list_keys[$urandom_range(0, list_keys.size() - 1)];
    case (sel)
      0: return 32'sh8000_0000;
      1: return 32'sh7FFF_FFFF;
      2: return KEY_W'($urandom_range(0, 3)) - 32'sd1;
      default: return $urandom;
    endcase
  endfunction

  // Mostly legal traffic that sweeps the list between empty and full; a little noise.
  task automatic test_random(input int n_items, input int idle_pct);
    item_t it;
    int    len;
    int    r;
    sender_idle_pct = idle_pct;
    for (int n = 0; n < n_items; n++) begin
      len = list_keys.size();
      if (len == CAPACITY) filling = 1'b0;
      if (len == 0) filling = 1'b1;
      r = $urandom_range(0, 99);
      if (r < 6) begin
        it = make_item(action_e'($urandom_range(0, 3)), $urandom_range(0, 31), $urandom);
      end else begin
        r = $urandom_range(0, 99);
        if (r < (filling ? 45 : 15)) it.action = ACT_INSERT;
        else if (r < 60) it.action = ACT_DELETE;
        else if (r < 78) it.action = ACT_MODIFY;
        else it.action = ACT_SEARCH;
        case (it.action)
          ACT_INSERT: it.pos = POS_W'($urandom_range(0, len));
          ACT_SEARCH: it.pos = POS_W'($urandom_range(0, 31));
          default:    it.pos = POS_W'((len == 0) ? 0 : $urandom_range(0, len - 1));
        endcase
        // hit the range check just past the end now and then
        if ($urandom_range(0, 19) == 0) it.pos = POS_W'(len + 1);
        it.key = pick_key(it.action == ACT_SEARCH);
      end
      send_item(it);
    end
    stop_sending();
  endtask

  initial begin
    rst_ni  = 1'b0;
    start_i = 1'b0;
    item_i  = '0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_directed();
    test_random(300, 0);
    test_random(200, 88);
    test_random(400, 21);

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("** ordered_list_position_engine: PASSED **");
    end else begin
      $display("** ordered_list_position_engine: FAILED **");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/olpe_pkg.sv
sv/olpe_cell.sv
sv/ordered_list_position_engine.sv
sv/olpe_checker.sv
verif/testbench.sv
